// ===== hdl/tmcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text-mode console writer package
// Transaction payload types, controller states, command and status groups,
// and the constants shared by the console writer modules.
// ----------------------------------------------------------------------------
package tmcw_pkg;

	localparam int unsigned COLUMNS_DEF = 80;
	localparam int unsigned ROWS_DEF    = 25;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned ROW_FW  = 5;
	localparam int unsigned COL_FW  = 7;

	localparam logic ACTION_PUT  = 1'b0;
	localparam logic ACTION_READ = 1'b1;

	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

	typedef struct packed {
		logic              action;
		logic [CHAR_W-1:0] char_code;
		logic [ROW_FW-1:0] cell_row;
		logic [COL_FW-1:0] cell_col;
	} tmcw_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] read_char;
		logic [COL_FW-1:0] cursor_col;
		logic [ROW_FW-1:0] cursor_row;
	} tmcw_result_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RESP
	} tmcw_state_t;

	typedef struct packed {
		logic accept;
		logic clear_step;
	} tmcw_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic clear_pend;
	} tmcw_status_t;

endpackage

// ===== hdl/tmcw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console writer controller
// Sequences the screen clear sweep, transaction intake and result delivery.
// ----------------------------------------------------------------------------
module tmcw_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	output logic                  result_valid,
	input  logic                  result_stall,
	input  tmcw_pkg::tmcw_status_t status,
	output tmcw_pkg::tmcw_cmd_t    cmd
);
	import tmcw_pkg::*;

	tmcw_state_t state_q;
	tmcw_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt      = state_q;
		item_stall     = 1'b1;
		result_valid   = 1'b0;
		cmd.clear_step = 1'b0;
		cmd.accept     = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (status.clear_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				item_stall = 1'b0;
				cmd.accept = item_valid;
				if (item_valid) begin
					state_nxt = ST_RESP;
				end
			end
			ST_RESP: begin
				result_valid = 1'b1;
				item_stall   = result_stall | status.clear_pend;
				cmd.accept   = item_valid & ~item_stall;
				if (!result_stall) begin
					if (status.clear_pend) begin
						state_nxt = ST_CLEAR;
					end else if (item_valid) begin
						state_nxt = ST_RESP;
					end else begin
						state_nxt = ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

endmodule

// ===== hdl/tmcw_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console writer datapath
// Screen memory, cursor registers, clear address counter and result register.
// ----------------------------------------------------------------------------
module tmcw_datapath #(
	parameter int unsigned COLUMNS = tmcw_pkg::COLUMNS_DEF,
	parameter int unsigned ROWS    = tmcw_pkg::ROWS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tmcw_pkg::tmcw_cmd_t    cmd,
	input  tmcw_pkg::tmcw_item_t   item,
	output tmcw_pkg::tmcw_status_t status,
	output tmcw_pkg::tmcw_result_t result
);
	import tmcw_pkg::*;

	localparam int unsigned CELLS  = ROWS * COLUMNS;
	localparam int unsigned COL_W  = $clog2(COLUMNS);
	localparam int unsigned ROW_W  = $clog2(ROWS);
	localparam int unsigned ADDR_W = $clog2(CELLS);
	localparam int unsigned COL_XW = (COL_W > COL_FW) ? COL_W : COL_FW;
	localparam int unsigned ROW_XW = (ROW_W > ROW_FW) ? ROW_W : ROW_FW;

	logic [CHAR_W-1:0] mem [CELLS];
	logic [CHAR_W-1:0] rd_q;
	logic              rd_ok_q;
	logic              pend_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] clr_q;

	logic              is_put;
	logic              is_nl;
	logic              col_last;
	logic              row_last;
	logic              row_adv;
	logic              in_range;
	logic [ADDR_W-1:0] raddr;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [CHAR_W-1:0] wdata;
	logic [COL_XW-1:0] col_x;
	logic [ROW_XW-1:0] row_x;

	assign is_put   = (item.action == ACTION_PUT);
	assign is_nl    = (item.char_code == NEWLINE_CODE);
	assign col_last = (col_q == COL_W'(COLUMNS - 1));
	assign row_last = (row_q == ROW_W'(ROWS - 1));
	assign row_adv  = is_nl | col_last;
	assign in_range = (32'(item.cell_row) < ROWS) && (32'(item.cell_col) < COLUMNS);
	assign raddr    = ADDR_W'(32'(item.cell_row) * COLUMNS + 32'(item.cell_col));

	assign we    = cmd.clear_step | (cmd.accept & is_put & ~is_nl);
	assign waddr = cmd.clear_step ? clr_q : addr_q;
	assign wdata = cmd.clear_step ? SPACE_CODE : item.char_code;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.accept && !is_put) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			addr_q  <= '0;
			clr_q   <= '0;
			rd_ok_q <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			if (cmd.clear_step) begin
				clr_q <= status.clear_last ? '0 : clr_q + 1'b1;
			end
			if (cmd.accept) begin
				rd_ok_q <= ~is_put & in_range;
				pend_q  <= is_put & row_adv & row_last;
				if (is_put) begin
					if (row_adv) begin
						col_q <= '0;
						if (row_last) begin
							row_q  <= '0;
							addr_q <= '0;
						end else begin
							row_q  <= row_q + 1'b1;
							addr_q <= addr_q + ADDR_W'(COLUMNS) - ADDR_W'(col_q);
						end
					end else begin
						col_q  <= col_q + 1'b1;
						addr_q <= addr_q + 1'b1;
					end
				end
			end
		end
	end

	assign status.clear_last = (clr_q == ADDR_W'(CELLS - 1));
	assign status.clear_pend = pend_q;

	assign col_x = COL_XW'(col_q);
	assign row_x = ROW_XW'(row_q);

	assign result.read_char  = rd_ok_q ? rd_q : '0;
	assign result.cursor_col = col_x[COL_FW-1:0];
	assign result.cursor_row = row_x[ROW_FW-1:0];

endmodule

// ===== hdl/text_mode_console_writer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text-mode console writer
// Character-cell console with a ROWS by COLUMNS screen memory and a cursor.
// ----------------------------------------------------------------------------
// Usage:
// Each item transaction either puts a character at the cursor or reads one
// screen cell. A newline moves the cursor to the start of the next row, any
// other byte is stored and advances the cursor. Leaving the last row homes
// the cursor and refills the screen with spaces.
// Every item gives exactly one result transaction in the cycle after it is
// accepted, carrying the read byte (zero for a put) and the cursor position.
// The block takes one item per cycle while results are taken as they appear
// and no sweep is pending, since the next item is accepted in the cycle its
// predecessor's result leaves. When the result channel stalls, the result
// holds and intake stalls. After reset and after a screen-full put, a sweep
// writes spaces into all ROWS*COLUMNS screen cells (2000 at the default
// size), one cell per cycle; intake stalls during the sweep.
// ----------------------------------------------------------------------------
module text_mode_console_writer_core #(
	parameter int unsigned COLUMNS = tmcw_pkg::COLUMNS_DEF,
	parameter int unsigned ROWS    = tmcw_pkg::ROWS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  tmcw_pkg::tmcw_item_t   item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output tmcw_pkg::tmcw_result_t result
);
	import tmcw_pkg::*;

	tmcw_cmd_t    cmd;
	tmcw_status_t status;

	tmcw_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	tmcw_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (item),
		.status (status),
		.result (result)
	);

endmodule

// ===== hdl/tmcw_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Console writer port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module tmcw_chk #(
	parameter int unsigned COLUMNS = tmcw_pkg::COLUMNS_DEF,
	parameter int unsigned ROWS    = tmcw_pkg::ROWS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  item_valid,
	input logic                  item_stall,
	input tmcw_pkg::tmcw_item_t   item,
	input logic                  result_valid,
	input logic                  result_stall,
	input tmcw_pkg::tmcw_result_t result
);
	import tmcw_pkg::*;

	logic item_acc;

	assign item_acc = item_valid & ~item_stall;

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("Stalled result transaction changed.");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc |=> result_valid)
		else $error("Accepted item gave no result in the next cycle.");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (32'(result.cursor_col) < COLUMNS) && (32'(result.cursor_row) < ROWS))
		else $error("Reported cursor lies outside the screen.");

	a_put_zero: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && (item.action == ACTION_PUT) |=> result.read_char == '0)
		else $error("Put transaction returned a nonzero character.");

	a_read_outside: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && (item.action == ACTION_READ) &&
		((32'(item.cell_row) >= ROWS) || (32'(item.cell_col) >= COLUMNS))
		|=> result.read_char == '0)
		else $error("Read outside the screen returned a nonzero character.");

endmodule

bind text_mode_console_writer_core tmcw_chk #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_chk (.*);

// ===== test/text_mode_console_writer_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text-mode console writer testbench
// Drives put-character and cell-read transactions into the console core and
// checks every result against a shadow screen and cursor kept in the bench.
// Directed tests cover reset contents, out-of-range reads, byte extremes,
// newline, line wrap and both ways of running off the last row. Random text
// with interleaved reads then runs under several idle and stall mixes, and
// one long receiver hold-off makes the core stall its intake.
// ----------------------------------------------------------------------------
module text_mode_console_writer_core_tb;

	import tmcw_pkg::*;

	localparam int unsigned COLS = COLUMNS_DEF;
	localparam int unsigned ROWS = ROWS_DEF;
	localparam int unsigned HOLD_OFF_CYCLES = 400;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         item_valid = 1'b0;
	logic         item_stall;
	tmcw_item_t   item = '0;
	logic         result_valid;
	logic         result_stall = 1'b0;
	tmcw_result_t result;

	logic [CHAR_W-1:0] shadow_screen [ROWS*COLS];
	int unsigned       track_col;
	int unsigned       track_row;
	tmcw_result_t      expected_results [$];
	tmcw_result_t      want_result;

	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;

	text_mode_console_writer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("text_mode_console_writer_core test failed");
		$finish;
	end

	function automatic void blank_shadow_screen();
		for (int i = 0; i < ROWS*COLS; i++) begin
			shadow_screen[i] = SPACE_CODE;
		end
	endfunction

	function automatic tmcw_result_t predict_console_result(tmcw_item_t it);
		tmcw_result_t res;
		res = '0;
		if (it.action == ACTION_READ) begin
			if (it.cell_row < ROWS && it.cell_col < COLS) begin
				res.read_char = shadow_screen[int'(it.cell_row)*COLS + int'(it.cell_col)];
			end
		end else begin
			if (it.char_code == NEWLINE_CODE) begin
				track_col = 0;
				track_row++;
			end else begin
				shadow_screen[track_row*COLS + track_col] = it.char_code;
				track_col++;
			end
			if (track_col >= COLS) begin
				track_col = 0;
				track_row++;
			end
			if (track_row >= ROWS) begin
				blank_shadow_screen();
				track_col = 0;
				track_row = 0;
			end
		end
		res.cursor_col = track_col[COL_FW-1:0];
		res.cursor_row = track_row[ROW_FW-1:0];
		return res;
	endfunction

	function automatic tmcw_item_t make_put(logic [CHAR_W-1:0] code);
		tmcw_item_t it;
		it.action    = ACTION_PUT;
		it.char_code = code;
		it.cell_row  = ROW_FW'($urandom_range(0, 31));
		it.cell_col  = COL_FW'($urandom_range(0, 127));
		return it;
	endfunction

	function automatic tmcw_item_t make_read(int unsigned r, int unsigned c);
		tmcw_item_t it;
		it.action    = ACTION_READ;
		it.char_code = CHAR_W'($urandom_range(0, 255));
		it.cell_row  = r[ROW_FW-1:0];
		it.cell_col  = c[COL_FW-1:0];
		return it;
	endfunction

	function automatic logic [CHAR_W-1:0] text_char();
		if ($urandom_range(0, 9) < 8) begin
			return CHAR_W'($urandom_range(32, 126));
		end
		return CHAR_W'($urandom_range(0, 255));
	endfunction

	function automatic tmcw_item_t random_read();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50 && track_col > 0) begin
			return make_read(track_row, track_col - 1);
		end else if (pick < 85) begin
			return make_read($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
		end
		return make_read($urandom_range(0, 31), $urandom_range(0, 127));
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic send_item(tmcw_item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (item_stall) begin
			@(posedge clk);
		end
		expected_results.push_back(predict_console_result(it));
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (hold_requests != hold_served) begin
			result_stall <= 1'b1;
			hold_served = hold_served + 1;
			hold_left = HOLD_OFF_CYCLES - 1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with no item pending", int'(result.read_char), 0);
			end else begin
				want_result = expected_results.pop_front();
				if (result.read_char !== want_result.read_char)
					report_mismatch("read_char", int'(result.read_char),
					                int'(want_result.read_char));
				if (result.cursor_col !== want_result.cursor_col)
					report_mismatch("cursor_col", int'(result.cursor_col),
					                int'(want_result.cursor_col));
				if (result.cursor_row !== want_result.cursor_row)
					report_mismatch("cursor_row", int'(result.cursor_row),
					                int'(want_result.cursor_row));
			end
		end
	end

	task automatic set_idling(int idle_pct, int stall_pct);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
	endtask

	task automatic test_reset_contents();
		set_idling(0, 0);
		send_item(make_read(0, 0));
		send_item(make_read(0, COLS - 1));
		send_item(make_read(ROWS - 1, 0));
		send_item(make_read(ROWS - 1, COLS - 1));
		send_item(make_read(ROWS, 0));
		send_item(make_read(0, COLS));
		send_item(make_read(ROWS - 1, COLS));
		send_item(make_read(31, 127));
	endtask

	task automatic test_put_extremes();
		set_idling(0, 0);
		send_item(make_put(8'd0));
		send_item(make_put(8'd255));
		send_item(make_put(SPACE_CODE));
		send_item(make_put(8'd9));
		send_item(make_put(8'd11));
		send_item(make_read(0, 0));
		send_item(make_read(0, 1));
		send_item(make_read(0, 4));
		send_item(make_put(NEWLINE_CODE));
		send_item(make_put(8'd127));
		send_item(make_read(1, 0));
		send_item(make_read(0, 5));
	endtask

	task automatic test_screen_full_by_newline();
		int unsigned lines;
		set_idling(22, 22);
		lines = ROWS - track_row;
		for (int i = 0; i < lines; i++) begin
			send_item(make_put(NEWLINE_CODE));
		end
		send_item(make_read(0, 0));
		send_item(make_read(1, 0));
	endtask

	task automatic test_screen_full_by_wrap();
		set_idling(22, 22);
		for (int i = 0; i < ROWS - 1; i++) begin
			send_item(make_put(NEWLINE_CODE));
		end
		for (int i = 0; i < COLS; i++) begin
			send_item(make_put(text_char()));
		end
		send_item(make_read(ROWS - 1, COLS - 1));
		send_item(make_read(ROWS - 1, 0));
	endtask

	task automatic test_random_text(int n_items, int idle_pct, int stall_pct);
		int sent;
		int line_len;
		int burst;
		set_idling(idle_pct, stall_pct);
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 7) == 0) begin
				burst = $urandom_range(3, 12);
				for (int i = 0; i < burst; i++) begin
					send_item(make_put(NEWLINE_CODE));
				end
				sent += burst;
			end
			line_len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 25)
			                                     : $urandom_range(60, 120);
			for (int k = 0; k < line_len; k++) begin
				if ($urandom_range(0, 9) < 3) begin
					send_item(random_read());
					sent++;
				end
				send_item(make_put(text_char()));
				sent++;
			end
			send_item(make_put(NEWLINE_CODE));
			sent++;
		end
	endtask

	task automatic test_backpressure();
		set_idling(0, 0);
		hold_requests = hold_requests + 1;
		for (int i = 0; i < 30; i++) begin
			if ($urandom_range(0, 3) == 0)
				send_item(random_read());
			else
				send_item(make_put(text_char()));
		end
	endtask

	initial begin
		blank_shadow_screen();
		track_col = 0;
		track_row = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_contents();
		test_put_extremes();
		test_screen_full_by_newline();
		test_screen_full_by_wrap();
		test_random_text(110, 0, 0);
		test_random_text(100, 86, 0);
		test_backpressure();
		test_random_text(100, 0, 86);
		test_random_text(110, 22, 22);

		item_valid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("text_mode_console_writer_core test passed");
		end else begin
			$display("text_mode_console_writer_core test failed");
		end
		$finish;
	end

endmodule
